// ===== hdl/ffa_pkg.sv =====
package ffa_pkg;

	localparam int HEAP_WORDS_DEF = 4096;
	localparam int MIN_HEAP_BYTES_DEF = 1024;

	localparam logic [1:0] OP_FORMAT = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_NOT_READY = 2'd2;
	localparam logic [1:0] ST_TOO_SMALL = 2'd3;

	localparam logic CFG_HEAP_START = 1'b0;
	localparam logic CFG_HEAP_END = 1'b1;

	localparam logic [31:0] USED_MARK = 32'd1;
	localparam logic [31:0] HDR_BYTES = 32'd8;
	localparam logic [31:0] SPLIT_MIN = 32'd16;

	typedef enum logic [4:0] {
		CMD_NOP,
		CMD_LATCH,
		CMD_NOTRDY,
		CMD_FMT_CHK,
		CMD_FW0,
		CMD_FW1,
		CMD_FW2,
		CMD_FW3,
		CMD_AL_LOOP,
		CMD_AL_CMP,
		CMD_AL_NEXT,
		CMD_UN0,
		CMD_UN1,
		CMD_UN2,
		CMD_UN3,
		CMD_UN4,
		CMD_AL_R0,
		CMD_AL_R1,
		CMD_AL_SPLIT,
		CMD_PS0,
		CMD_PS1,
		CMD_AP0,
		CMD_AP1,
		CMD_AP2,
		CMD_RL0,
		CMD_RL1,
		CMD_RL2,
		CMD_RL3,
		CMD_RL4,
		CMD_RL5,
		CMD_RL6,
		CMD_FINISH
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       heap_ready;
		logic       too_small;
		logic       walk_stop;
		logic       fits;
		logic       flag;
		logic       pred_free;
	} dp_stat_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_DISPATCH,
		S_FMT_CHK,
		S_FW0,
		S_FW1,
		S_FW2,
		S_FW3,
		S_AL_LOOP,
		S_AL_CMP,
		S_AL_NEXT,
		S_UN0,
		S_UN1,
		S_UN2,
		S_UN3,
		S_UN4,
		S_AL_R0,
		S_AL_R1,
		S_A1_PS0,
		S_A1_PS1,
		S_AL_SPLIT,
		S_A2_PS0,
		S_A2_PS1,
		S_AP0,
		S_AP1,
		S_AP2,
		S_RL0,
		S_RL1,
		S_RL2,
		S_R1_PS0,
		S_R1_PS1,
		S_RL3,
		S_RL4,
		S_RL5,
		S_RL6,
		S_R2_PS0,
		S_R2_PS1,
		S_FIN
	} state_t;

endpackage

// ===== hdl/first_fit_heap_allocator.sv =====
// First-fit heap manager with boundary tags and a doubly linked free list kept in an internal
// word memory (one write and one registered read per cycle). Pulse start while busy is low;
// exactly one result appears later for one cycle with done high and cannot be stalled.
// Busy stays high after the accepting edge until the item is over, and done shows in the first
// cycle after busy falls. How long busy stays high depends on the item: a too-small heap ends a
// format early; an allocation lasts longer with a split and with each free region it skips; a
// release lasts longer when it merges with a free neighbour; an item on an unformatted heap, or
// operation three, ends soonest. The memory port sets this timing: each tag or link read or write
// is its own memory access. Configuration writes are always accepted and belong in idle periods.
module first_fit_heap_allocator import ffa_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF,
	parameter int MIN_HEAP_BYTES = MIN_HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] request_size,
	input  logic [31:0] block_address,
	output logic        done,
	output logic [31:0] granted_address,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t     cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ffa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
	);

	ffa_datapath #(.HEAP_WORDS(HEAP_WORDS), .MIN_HEAP_BYTES(MIN_HEAP_BYTES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.operation(operation),
		.request_size(request_size),
		.block_address(block_address),
		.cfg_wr(cfg_valid & cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.granted_address(granted_address),
		.status(status),
		.done(done)
	);

endmodule

// ===== hdl/ffa_ram.sv =====
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ffa_ctrl.sv =====
module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output cmd_t     cmd,
	output logic     busy
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:     if (start) state_nx = S_DISPATCH;
			S_DISPATCH: begin
				if (stat.op == OP_FORMAT) state_nx = S_FMT_CHK;
				else if (stat.op == OP_ALLOC && stat.heap_ready) state_nx = S_AL_LOOP;
				else if (stat.op == OP_RELEASE && stat.heap_ready) state_nx = S_RL0;
				else state_nx = S_FIN;
			end
			S_FMT_CHK:  state_nx = stat.too_small ? S_FIN : S_FW0;
			S_FW0:      state_nx = S_FW1;
			S_FW1:      state_nx = S_FW2;
			S_FW2:      state_nx = S_FW3;
			S_FW3:      state_nx = S_AP0;
			S_AL_LOOP:  state_nx = stat.walk_stop ? S_FIN : S_AL_CMP;
			S_AL_CMP:   state_nx = stat.fits ? S_UN0 : S_AL_NEXT;
			S_AL_NEXT:  state_nx = S_AL_LOOP;
			S_UN0:      state_nx = S_UN1;
			S_UN1:      state_nx = S_UN2;
			S_UN2:      state_nx = S_UN3;
			S_UN3:      state_nx = S_UN4;
			S_UN4:      state_nx = (stat.op == OP_ALLOC) ? S_AL_R0 : S_RL3;
			S_AL_R0:    state_nx = S_AL_R1;
			S_AL_R1:    state_nx = S_A1_PS0;
			S_A1_PS0:   state_nx = S_A1_PS1;
			S_A1_PS1:   state_nx = stat.flag ? S_AL_SPLIT : S_FIN;
			S_AL_SPLIT: state_nx = S_A2_PS0;
			S_A2_PS0:   state_nx = S_A2_PS1;
			S_A2_PS1:   state_nx = S_AP0;
			S_AP0:      state_nx = S_AP1;
			S_AP1:      state_nx = S_AP2;
			S_AP2:      state_nx = S_FIN;
			S_RL0:      state_nx = S_RL1;
			S_RL1:      state_nx = S_RL2;
			S_RL2:      state_nx = S_R1_PS0;
			S_R1_PS0:   state_nx = S_R1_PS1;
			S_R1_PS1:   state_nx = stat.flag ? S_UN0 : S_RL3;
			S_RL3:      state_nx = S_RL4;
			S_RL4:      state_nx = stat.pred_free ? S_RL5 : S_AP0;
			S_RL5:      state_nx = S_RL6;
			S_RL6:      state_nx = S_R2_PS0;
			S_R2_PS0:   state_nx = S_R2_PS1;
			S_R2_PS1:   state_nx = S_FIN;
			S_FIN:      state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = CMD_NOP;
		case (state_q)
			S_IDLE:     if (start) cmd = CMD_LATCH;
			S_DISPATCH: begin
				if ((stat.op == OP_ALLOC || stat.op == OP_RELEASE) && !stat.heap_ready) begin
					cmd = CMD_NOTRDY;
				end
			end
			S_FMT_CHK:  cmd = CMD_FMT_CHK;
			S_FW0:      cmd = CMD_FW0;
			S_FW1:      cmd = CMD_FW1;
			S_FW2:      cmd = CMD_FW2;
			S_FW3:      cmd = CMD_FW3;
			S_AL_LOOP:  cmd = CMD_AL_LOOP;
			S_AL_CMP:   cmd = CMD_AL_CMP;
			S_AL_NEXT:  cmd = CMD_AL_NEXT;
			S_UN0:      cmd = CMD_UN0;
			S_UN1:      cmd = CMD_UN1;
			S_UN2:      cmd = CMD_UN2;
			S_UN3:      cmd = CMD_UN3;
			S_UN4:      cmd = CMD_UN4;
			S_AL_R0:    cmd = CMD_AL_R0;
			S_AL_R1:    cmd = CMD_AL_R1;
			S_A1_PS0:   cmd = CMD_PS0;
			S_A1_PS1:   cmd = CMD_PS1;
			S_AL_SPLIT: cmd = CMD_AL_SPLIT;
			S_A2_PS0:   cmd = CMD_PS0;
			S_A2_PS1:   cmd = CMD_PS1;
			S_AP0:      cmd = CMD_AP0;
			S_AP1:      cmd = CMD_AP1;
			S_AP2:      cmd = CMD_AP2;
			S_RL0:      cmd = CMD_RL0;
			S_RL1:      cmd = CMD_RL1;
			S_RL2:      cmd = CMD_RL2;
			S_R1_PS0:   cmd = CMD_PS0;
			S_R1_PS1:   cmd = CMD_PS1;
			S_RL3:      cmd = CMD_RL3;
			S_RL4:      cmd = CMD_RL4;
			S_RL5:      cmd = CMD_RL5;
			S_RL6:      cmd = CMD_RL6;
			S_R2_PS0:   cmd = CMD_PS0;
			S_R2_PS1:   cmd = CMD_PS1;
			S_FIN:      cmd = CMD_FINISH;
			default:    cmd = CMD_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== hdl/ffa_datapath.sv =====
module ffa_datapath import ffa_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF,
	parameter int MIN_HEAP_BYTES = MIN_HEAP_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  operation,
	input  logic [15:0] request_size,
	input  logic [31:0] block_address,
	input  logic        cfg_wr,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	output logic [31:0] granted_address,
	output logic [1:0]  status,
	output logic        done
);

	localparam int AW = $clog2(HEAP_WORDS);
	localparam int SW = $clog2(HEAP_WORDS + 2);

	function automatic logic [AW-1:0] widx(input logic [31:0] a);
		return a[AW+1:2];
	endfunction

	// control state
	logic [31:0] hs_q, he_q, hn_q, hp_q;
	logic        rdy_q, done_q;
	// working registers
	logic [1:0]  op_q, st_q;
	logic [31:0] want_q, blk_q, n_q, u_q, p_q, x_q, r_q, s_q, a_q, cur_q, addr_q;
	logic [SW-1:0] steps_q;
	logic        flag_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	ffa_ram #(.WIDTH(32), .DEPTH(HEAP_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// format bounds, exact without wrap
	logic [33:0] fstart, fend;
	logic [31:0] ftail, fsz;
	logic        too_small;
	assign fstart = ({2'b0, hs_q} + 34'd3) & ~34'd3;
	assign fend = {2'b0, he_q[31:2], 2'b0};
	assign too_small = (fstart + 34'(MIN_HEAP_BYTES)) >= fend;
	assign ftail = fend[31:0] - HDR_BYTES;
	assign fsz = ftail - fstart[31:0] - HDR_BYTES;

	logic [31:0] rmask, rest;
	assign rmask = {rdata[31:2], 2'b0};
	assign rest = rdata - want_q;

	assign stat.op = op_q;
	assign stat.heap_ready = rdy_q;
	assign stat.too_small = too_small;
	assign stat.walk_stop = (n_q == 32'd0) || (steps_q > SW'(HEAP_WORDS));
	assign stat.fits = rdata >= want_q;
	assign stat.flag = flag_q;
	assign stat.pred_free = (rdata[1:0] == 2'b00);

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (cmd)
			CMD_FW0:     begin we = 1'b1; waddr = widx(r_q); wdata = USED_MARK; end
			CMD_FW1:     begin we = 1'b1; waddr = widx(r_q + 32'd4); wdata = s_q; end
			CMD_FW2:     begin we = 1'b1; waddr = widx(x_q); wdata = s_q; end
			CMD_FW3:     begin we = 1'b1; waddr = widx(x_q + 32'd4); wdata = USED_MARK; end
			CMD_AL_LOOP: raddr = widx(n_q - 32'd4);
			CMD_AL_CMP:  raddr = widx(n_q);
			CMD_UN0:     raddr = widx(u_q + 32'd4);
			CMD_UN1:     raddr = widx(u_q);
			CMD_UN3:     begin we = (p_q != 32'd0); waddr = widx(p_q); wdata = x_q; end
			CMD_UN4:     begin we = (x_q != 32'd0); waddr = widx(x_q + 32'd4); wdata = p_q; end
			CMD_AL_R0:   raddr = widx(n_q - 32'd4);
			CMD_PS0:     begin we = 1'b1; waddr = widx(r_q + 32'd4); wdata = s_q; end
			CMD_PS1:     begin
				we = 1'b1;
				waddr = widx(r_q + HDR_BYTES + {s_q[31:2], 2'b0});
				wdata = s_q;
			end
			CMD_AP0:     begin we = 1'b1; waddr = widx(a_q); wdata = 32'd0; end
			CMD_AP1:     begin we = 1'b1; waddr = widx(a_q + 32'd4); wdata = hp_q; end
			CMD_AP2:     begin we = (hp_q != 32'd0); waddr = widx(hp_q); wdata = a_q; end
			CMD_RL0:     raddr = widx(blk_q - 32'd4);
			CMD_RL1:     raddr = widx(r_q + 32'd12 + rmask);
			CMD_RL3:     raddr = widx(r_q);
			CMD_RL4:     raddr = widx(r_q - rmask - HDR_BYTES + 32'd4);
			CMD_RL5:     raddr = widx(r_q + 32'd4);
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= 32'd0;
			he_q <= 32'd16384;
			hn_q <= 32'd0;
			hp_q <= 32'd0;
			rdy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd == CMD_FINISH);
			if (cfg_wr) begin
				if (cfg_index == CFG_HEAP_START) hs_q <= cfg_data;
				else he_q <= cfg_data;
			end
			case (cmd)
				CMD_FW3: begin hn_q <= 32'd0; hp_q <= 32'd0; rdy_q <= 1'b1; end
				CMD_UN3: if (p_q == 32'd0) hn_q <= x_q;
				CMD_UN4: if (x_q == 32'd0) hp_q <= p_q;
				CMD_AP2: begin
					if (hp_q == 32'd0) hn_q <= a_q;
					hp_q <= a_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LATCH: begin
				op_q <= operation;
				want_q <= ({16'd0, request_size} + 32'd7) & ~32'd7;
				blk_q <= block_address;
				n_q <= hn_q;
				steps_q <= '0;
				addr_q <= 32'd0;
				st_q <= ST_OK;
			end
			CMD_NOTRDY: st_q <= ST_NOT_READY;
			CMD_FMT_CHK: begin
				if (too_small) st_q <= ST_TOO_SMALL;
				r_q <= fstart[31:0];
				x_q <= ftail;
				s_q <= fsz;
				a_q <= fstart[31:0] + HDR_BYTES;
			end
			CMD_AL_LOOP: begin
				if (n_q == 32'd0 || steps_q > SW'(HEAP_WORDS)) st_q <= ST_NO_SPACE;
			end
			CMD_AL_CMP: u_q <= n_q;
			CMD_AL_NEXT: begin
				n_q <= rdata;
				steps_q <= steps_q + SW'(1);
			end
			CMD_UN1: p_q <= (u_q == 32'd0) ? hp_q : rdata;
			CMD_UN2: x_q <= (u_q == 32'd0) ? hn_q : rdata;
			CMD_AL_R1: begin
				cur_q <= rest;
				flag_q <= rest >= SPLIT_MIN;
				r_q <= n_q - HDR_BYTES;
				s_q <= (rest >= SPLIT_MIN) ? (want_q | USED_MARK) : (rdata | USED_MARK);
				addr_q <= n_q;
			end
			CMD_AL_SPLIT: begin
				r_q <= n_q + want_q;
				s_q <= cur_q - HDR_BYTES;
				a_q <= n_q + want_q + HDR_BYTES;
			end
			CMD_RL0: r_q <= blk_q - HDR_BYTES;
			CMD_RL1: begin
				cur_q <= rmask;
				u_q <= r_q + 32'd16 + rmask;
			end
			CMD_RL2: begin
				flag_q <= (rdata[1:0] == 2'b00);
				s_q <= (rdata[1:0] == 2'b00) ? (cur_q + rdata + HDR_BYTES) : cur_q;
			end
			CMD_RL4: begin
				p_q <= r_q - rmask - HDR_BYTES;
				a_q <= r_q + HDR_BYTES;
			end
			CMD_RL5: cur_q <= rdata;
			CMD_RL6: begin
				s_q <= cur_q + rdata + HDR_BYTES;
				r_q <= p_q;
			end
			default: ;
		endcase
	end

	assign granted_address = addr_q;
	assign status = st_q;
	assign done = done_q;

endmodule

// ===== hdl/ffa_checker.sv =====
module ffa_checker import ffa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [31:0] granted_address,
	input logic [1:0]  status
);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	// results only show once the work is over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe repeated");

	// failures and non-allocating items give address zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_address == 32'd0)
		else $error("nonzero address on failed item");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.granted_address(granted_address), .status(status)
);
